/* hdl/swtt_pkg.sv */
// ============================================================================
// swtt_pkg
// Shared constants and types for the send-window timeout tracker: window
// geometry, operation and register codes, beat payloads and controller states.
// ============================================================================
package swtt_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int TIME_W       = 32;
    localparam int SEQ_W        = 32;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int ADDR_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_W        = 32;

    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 32'd200000;
    localparam logic [CFG_W-1:0] LIMIT_RESET   = 32'd100000;
    localparam logic [31:0]      COUNT_MAX     = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_SEND  = 2'd0,
        OP_ACK   = 2'd1,
        OP_CHECK = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT = 1'b0,
        CFG_LIMIT   = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_JUDGE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] ack_seq;
        logic [31:0] now_time;
    } t_in;

    typedef struct packed {
        logic        send_accepted;
        logic [31:0] sent_seq;
        logic        ack_matched;
        logic        timed_out;
        logic [31:0] expired_seq;
        logic [6:0]  occupancy;
        logic [31:0] sent_total;
        logic [31:0] received_total;
        logic [31:0] lost_total;
        logic        all_done;
    } t_out;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] stamp;
    } t_entry;

endpackage

/* hdl/swtt_ram.sv */
// ============================================================================
// swtt_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ============================================================================
module swtt_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

/* hdl/send_window_timeout_tracker.sv */
// ============================================================================
// send_window_timeout_tracker
// Sequencing: send, unknown op, or ack/check on an empty window go straight
// to the done state, which loads the output register once it is free.
// Ack/check scan each entry with a read then an evaluate step, check adds a
// judge step, removal adds a read and a write step per entry moved down;
// each registered RAM read is waited out and used before the next is issued.
// Throughput: one item at a time; next beat taken once the result is loaded.
// Reset: synchronous active low; clears counters, sequence number, FSM, out valid.
// ============================================================================
// In-flight entries {seq, send time} live in one RAM in send order. A send
// appends at the fill count. An ack scans from the bottom for the first
// matching sequence; a check scans every entry for the largest elapsed time.
// A removed entry is closed up by copying each later entry one slot down,
// which keeps the order the sender issued them in.
module send_window_timeout_tracker
    import swtt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == COUNT_MAX) ? v : v + 32'd1;
    endfunction

    // FSM and bookkeeping registers
    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [SEQ_W-1:0]  r_ack, n_ack;
    logic [TIME_W-1:0] r_now, n_now;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [ADDR_W-1:0] r_best_pos, n_best_pos;
    logic [TIME_W-1:0] r_best_el, n_best_el;
    logic [SEQ_W-1:0]  r_best_seq, n_best_seq;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SEQ_W-1:0]  r_next_seq, n_next_seq;
    logic [31:0]       r_sent, n_sent;
    logic [31:0]       r_recv, n_recv;
    logic [CFG_W-1:0]  r_timeout;
    logic [CFG_W-1:0]  r_limit;

    // per-item result flags
    logic              r_accepted, n_accepted;
    logic [SEQ_W-1:0]  r_sseq, n_sseq;
    logic              r_matched, n_matched;
    logic              r_lost, n_lost;
    logic [SEQ_W-1:0]  r_eseq, n_eseq;

    // output register
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    // RAM port
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_wr_addr;
    logic [$bits(t_entry)-1:0] ram_wr_data;
    logic                   ram_re;
    logic [ADDR_W-1:0]      ram_rd_addr;
    logic [$bits(t_entry)-1:0] ram_q;

    // decode helpers
    logic              in_fire;
    t_op               in_op;
    t_entry            rd_entry;
    t_entry            wr_entry;
    logic [TIME_W-1:0] elapsed;
    logic              can_send;
    logic              scan_last;
    logic              ack_hit;
    logic              better;
    logic              expired;
    logic              best_has_tail;
    logic              shift_more;
    logic              out_free;

    swtt_ram #(
        .DATA_W ($bits(t_entry)),
        .DEPTH  (WINDOW_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_re      (ram_re),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_q)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign in_op      = t_op'(i_in_data.operation);
    assign rd_entry   = t_entry'(ram_q);
    assign elapsed    = r_now - rd_entry.stamp;
    assign can_send   = (r_count < CNT_W'(WINDOW_DEPTH)) && (r_sent < r_limit);
    assign scan_last  = (CNT_W'(r_pos) + CNT_W'(1)) >= r_count;
    assign ack_hit    = (rd_entry.seq == r_ack);
    assign better     = (r_pos == '0) || (elapsed > r_best_el);
    assign expired    = {{CFG_W{1'b0}}, r_best_el} >= {{TIME_W{1'b0}}, r_timeout};
    assign best_has_tail = (CNT_W'(r_best_pos) + CNT_W'(1)) < r_count;
    // r_count already holds the reduced fill while moving entries down
    assign shift_more = (CNT_W'(r_pos) + CNT_W'(1)) < r_count;
    assign out_free   = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if ((in_op == OP_ACK || in_op == OP_CHECK) && (r_count != '0)) begin
                        n_state = S_SCAN_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                if (r_op == OP_ACK) begin
                    if (ack_hit) begin
                        n_state = scan_last ? S_DONE : S_SHIFT_RD;
                    end else begin
                        n_state = scan_last ? S_DONE : S_SCAN_RD;
                    end
                end else begin
                    n_state = scan_last ? S_JUDGE : S_SCAN_RD;
                end
            end
            S_JUDGE: begin
                n_state = (expired && best_has_tail) ? S_SHIFT_RD : S_DONE;
            end
            S_SHIFT_RD: begin
                n_state = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                n_state = shift_more ? S_SHIFT_RD : S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_op        = r_op;
        n_ack       = r_ack;
        n_now       = r_now;
        n_pos       = r_pos;
        n_best_pos  = r_best_pos;
        n_best_el   = r_best_el;
        n_best_seq  = r_best_seq;
        n_count     = r_count;
        n_next_seq  = r_next_seq;
        n_sent      = r_sent;
        n_recv      = r_recv;
        n_accepted  = r_accepted;
        n_sseq      = r_sseq;
        n_matched   = r_matched;
        n_lost      = r_lost;
        n_eseq      = r_eseq;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        wr_entry       = rd_entry;
        ram_we         = 1'b0;
        ram_wr_addr    = r_pos;
        ram_re         = 1'b0;
        ram_rd_addr    = r_pos;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_op       = in_op;
                    n_ack      = SEQ_W'(i_in_data.ack_seq);
                    n_now      = TIME_W'(i_in_data.now_time);
                    n_pos      = '0;
                    n_accepted = 1'b0;
                    n_sseq     = '0;
                    n_matched  = 1'b0;
                    n_lost     = 1'b0;
                    n_eseq     = '0;
                    if (in_op == OP_SEND && can_send) begin
                        // append at the fill count
                        wr_entry.seq   = r_next_seq;
                        wr_entry.stamp = TIME_W'(i_in_data.now_time);
                        ram_we         = 1'b1;
                        ram_wr_addr    = r_count[ADDR_W-1:0];
                        n_count        = r_count + CNT_W'(1);
                        n_sseq         = r_next_seq;
                        n_accepted     = 1'b1;
                        n_next_seq     = r_next_seq + SEQ_W'(1);
                        n_sent         = sat_inc(r_sent);
                    end
                end
            end
            S_SCAN_RD: begin
                ram_re      = 1'b1;
                ram_rd_addr = r_pos;
            end
            S_SCAN_EV: begin
                if (r_op == OP_ACK) begin
                    if (ack_hit) begin
                        // hold the hit position as the start of the close-up
                        n_matched = 1'b1;
                        n_recv    = sat_inc(r_recv);
                        n_count   = r_count - CNT_W'(1);
                    end else if (!scan_last) begin
                        n_pos = r_pos + ADDR_W'(1);
                    end
                end else begin
                    if (better) begin
                        n_best_el  = elapsed;
                        n_best_pos = r_pos;
                        n_best_seq = rd_entry.seq;
                    end
                    if (!scan_last) begin
                        n_pos = r_pos + ADDR_W'(1);
                    end
                end
            end
            S_JUDGE: begin
                if (expired) begin
                    n_lost  = 1'b1;
                    n_eseq  = r_best_seq;
                    n_count = r_count - CNT_W'(1);
                    n_pos   = r_best_pos;
                end
            end
            S_SHIFT_RD: begin
                ram_re      = 1'b1;
                ram_rd_addr = r_pos + ADDR_W'(1);
            end
            S_SHIFT_WR: begin
                // move the later entry down one slot
                ram_we      = 1'b1;
                ram_wr_addr = r_pos;
                n_pos       = r_pos + ADDR_W'(1);
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.send_accepted  = r_accepted;
                    n_out.sent_seq       = 32'(r_sseq);
                    n_out.ack_matched    = r_matched;
                    n_out.timed_out      = r_lost;
                    n_out.expired_seq    = 32'(r_eseq);
                    n_out.occupancy      = 7'(r_count);
                    n_out.sent_total     = r_sent;
                    n_out.received_total = r_recv;
                    n_out.lost_total     = r_sent - r_recv;
                    n_out.all_done       = (r_sent >= r_limit) && (r_count == '0);
                end
            end
            default: begin
            end
        endcase

        ram_wr_data = wr_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_next_seq  <= '0;
            r_sent      <= '0;
            r_recv      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_next_seq  <= n_next_seq;
            r_sent      <= n_sent;
            r_recv      <= n_recv;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration registers, written whenever the enable is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_limit   <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TIMEOUT: r_timeout <= i_cfg_data;
                CFG_LIMIT:   r_limit   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_ack      <= n_ack;
        r_now      <= n_now;
        r_pos      <= n_pos;
        r_best_pos <= n_best_pos;
        r_best_el  <= n_best_el;
        r_best_seq <= n_best_seq;
        r_accepted <= n_accepted;
        r_sseq     <= n_sseq;
        r_matched  <= n_matched;
        r_lost     <= n_lost;
        r_eseq     <= n_eseq;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
